@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// Each macro checks at the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_pkg
// Types and constants of the light sphere scissor rectangle pipeline.
// ----------------------------------------------------------------------------
package lsr_pkg;

   localparam int NSTAGE = 24;
   localparam int ST_XF  = 0;
   localparam int ST_PJ  = 3;
   localparam int ST_DV  = 5;
   localparam int ST_PX  = 22;

   localparam int PRW  = 48;
   localparam int VW   = 35;
   localparam int CW   = 36;
   localparam int DW   = 32;
   localparam int MW   = 52;
   localparam int NW   = 56;
   localparam int QB   = 17;
   localparam int NLANE = 4;

   localparam logic [QB-1:0] NDC_ONE = 17'h10000;

   typedef enum logic [2:0] {
      REG_ROT0     = 3'd0,
      REG_ROT1     = 3'd1,
      REG_ROT2     = 3'd2,
      REG_TRANS_XY = 3'd3,
      REG_TRANS_Z  = 3'd4,
      REG_PROJ     = 3'd5,
      REG_CLIP     = 3'd6,
      REG_VIEWPORT = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic signed [CW-1:0] coord;
      logic signed [DW-1:0] depth;
   } lane_type;

   typedef struct packed {
      logic [NW-1:0] rem;
      logic [DW-1:0] den;
      logic [QB-1:0] quo;
      logic          neg;
      logic          zero;
      logic          ovf;
   } dstage_type;

endpackage

@@ rtl/light_sphere_scissor_rect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sphere_scissor_rect
// Screen-space scissor rectangle of a light's bounding sphere.
// ----------------------------------------------------------------------------
// A request carries a light center in world space and its radius; the
// response carries the left, right, top and bottom pixel edges. Both
// channels use valid and stall, and a request is taken at a rising edge
// with valid high and stall low.
// The view matrix, projection scales, clip planes and viewport size are set
// through the CSR port, by the user only while no request is in flight; the
// block does not enforce this. It is a 24-stage pipeline: view transform,
// edge depths, projection multiply, a 17-stage divider with one quotient bit
// per stage, and the viewport mapping. One request enters per cycle unless
// every stage is full and the response side stalls. A full stage holds when
// its successor is full and held, so empty stages close up while the
// response side stalls and requests keep entering until every stage is full.
// Synchronous reset clears all stage valid bits and all CSRs to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module light_sphere_scissor_rect (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [30:0]        req_radius,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_rect_left,
   output logic [15:0]        rsp_rect_right,
   output logic [15:0]        rsp_rect_top,
   output logic [15:0]        rsp_rect_bottom,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [5:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);

   logic [47:0] rot0_ff;
   logic [47:0] rot1_ff;
   logic [47:0] rot2_ff;
   logic [63:0] trans_xy_ff;
   logic [31:0] trans_z_ff;
   logic [31:0] proj_ff;
   logic [63:0] clip_ff;
   logic [31:0] vport_ff;

   logic                        csr_wr;
   lsr_pkg::csr_reg_type        csr_sel;

   logic [lsr_pkg::NSTAGE-1:0]  valid_ff;
   logic [lsr_pkg::NSTAGE-1:0]  valid_in;
   logic [lsr_pkg::NSTAGE:0]    en_w;

   lsr_pkg::lane_type           lane_w [lsr_pkg::NLANE];
   lsr_pkg::dstage_type         pj_w   [lsr_pkg::NLANE];
   lsr_pkg::dstage_type         dv_w   [lsr_pkg::NLANE];
   logic [15:0]                 pix_w  [lsr_pkg::NLANE];

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = lsr_pkg::csr_reg_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff     <= '0;
         rot1_ff     <= '0;
         rot2_ff     <= '0;
         trans_xy_ff <= '0;
         trans_z_ff  <= '0;
         proj_ff     <= '0;
         clip_ff     <= '0;
         vport_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_sel)
            lsr_pkg::REG_ROT0:     rot0_ff     <= csr_pwdata[47:0];
            lsr_pkg::REG_ROT1:     rot1_ff     <= csr_pwdata[47:0];
            lsr_pkg::REG_ROT2:     rot2_ff     <= csr_pwdata[47:0];
            lsr_pkg::REG_TRANS_XY: trans_xy_ff <= csr_pwdata;
            lsr_pkg::REG_TRANS_Z:  trans_z_ff  <= csr_pwdata[31:0];
            lsr_pkg::REG_PROJ:     proj_ff     <= csr_pwdata[31:0];
            lsr_pkg::REG_CLIP:     clip_ff     <= csr_pwdata;
            lsr_pkg::REG_VIEWPORT: vport_ff    <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         lsr_pkg::REG_ROT0:     csr_prdata = 64'(rot0_ff);
         lsr_pkg::REG_ROT1:     csr_prdata = 64'(rot1_ff);
         lsr_pkg::REG_ROT2:     csr_prdata = 64'(rot2_ff);
         lsr_pkg::REG_TRANS_XY: csr_prdata = trans_xy_ff;
         lsr_pkg::REG_TRANS_Z:  csr_prdata = 64'(trans_z_ff);
         lsr_pkg::REG_PROJ:     csr_prdata = 64'(proj_ff);
         lsr_pkg::REG_CLIP:     csr_prdata = clip_ff;
         lsr_pkg::REG_VIEWPORT: csr_prdata = 64'(vport_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_comb begin
      en_w[lsr_pkg::NSTAGE] = !rsp_stall;
      for (int s = lsr_pkg::NSTAGE - 1; s >= 0; s--) begin
         en_w[s] = !valid_ff[s] || en_w[s+1];
      end
   end

   assign valid_in = {valid_ff[lsr_pkg::NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < lsr_pkg::NSTAGE; s++) begin
            if (en_w[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   assign req_stall = !en_w[0];
   assign rsp_valid = valid_ff[lsr_pkg::NSTAGE-1];

   lsr_xform u_xform (
      .clock    (clock),
      .en       (en_w[lsr_pkg::ST_XF +: 3]),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .pos_z    (req_pos_z),
      .radius   (req_radius),
      .rot_row0 (rot0_ff),
      .rot_row1 (rot1_ff),
      .rot_row2 (rot2_ff),
      .trans_xy (trans_xy_ff),
      .trans_z  (trans_z_ff),
      .clip     (clip_ff),
      .lane     (lane_w)
   );

   for (genvar l = 0; l < lsr_pkg::NLANE; l++) begin : g_lane
      localparam bit IS_Y = (l >= 2);

      lsr_proj u_proj (
         .clock (clock),
         .en    (en_w[lsr_pkg::ST_PJ +: 2]),
         .lane  (lane_w[l]),
         .scale (IS_Y ? proj_ff[31:16] : proj_ff[15:0]),
         .dout  (pj_w[l])
      );

      lsr_div u_div (
         .clock (clock),
         .en    (en_w[lsr_pkg::ST_DV +: lsr_pkg::QB]),
         .din   (pj_w[l]),
         .dout  (dv_w[l])
      );

      lsr_pix u_pix (
         .clock (clock),
         .en    (en_w[lsr_pkg::ST_PX +: 2]),
         .din   (dv_w[l]),
         .size  (IS_Y ? vport_ff[31:16] : vport_ff[15:0]),
         .flip  (IS_Y),
         .pix   (pix_w[l])
      );
   end

   assign rsp_rect_left   = pix_w[0];
   assign rsp_rect_right  = pix_w[1];
   assign rsp_rect_top    = pix_w[2];
   assign rsp_rect_bottom = pix_w[3];

   `ASSERT_IMPLIES(a_stall_full, req_stall, valid_ff[0], "request stalled with empty first stage")
   `ASSERT_IMPLIES(a_no_stall, !rsp_stall, !req_stall, "request stalled while output drains")
   `ASSERT_NEXT(a_enter, req_valid && !req_stall, valid_ff[0], "accepted request was lost")
   `ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid, "held response dropped")

endmodule

@@ rtl/lsr_xform.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_xform
// View transform of the light center and edge points with clamped depths.
// ----------------------------------------------------------------------------
module lsr_xform (
   input  logic                  clock,
   input  logic [2:0]            en,
   input  logic signed [31:0]    pos_x,
   input  logic signed [31:0]    pos_y,
   input  logic signed [31:0]    pos_z,
   input  logic [30:0]           radius,
   input  logic [47:0]           rot_row0,
   input  logic [47:0]           rot_row1,
   input  logic [47:0]           rot_row2,
   input  logic [63:0]           trans_xy,
   input  logic [31:0]           trans_z,
   input  logic [63:0]           clip,
   output lsr_pkg::lane_type     lane [lsr_pkg::NLANE]
);

   logic signed [31:0]               pos_w [3];
   logic [47:0]                      row_w [3];
   logic signed [lsr_pkg::PRW-1:0]   prod_ff [3][3];
   logic [30:0]                      r0_ff;
   logic [30:0]                      r1_ff;
   logic signed [lsr_pkg::VW-1:0]    v_ff [3];
   logic signed [lsr_pkg::VW-1:0]    v_in [3];
   logic signed [31:0]               t_w [3];
   lsr_pkg::lane_type                lane_ff [lsr_pkg::NLANE];
   lsr_pkg::lane_type                lane_in [lsr_pkg::NLANE];

   assign pos_w[0] = pos_x;
   assign pos_w[1] = pos_y;
   assign pos_w[2] = pos_z;
   assign row_w[0] = rot_row0;
   assign row_w[1] = rot_row1;
   assign row_w[2] = rot_row2;
   assign t_w[0]   = $signed(trans_xy[31:0]);
   assign t_w[1]   = $signed(trans_xy[63:32]);
   assign t_w[2]   = $signed(trans_z);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= pos_w[r] * $signed(row_w[r][16*c +: 16]);
            end
         end
         r0_ff <= radius;
      end
   end

   always_comb begin
      logic signed [lsr_pkg::PRW+1:0] acc;
      for (int c = 0; c < 3; c++) begin
         acc = (lsr_pkg::PRW+2)'(prod_ff[0][c]) + (lsr_pkg::PRW+2)'(prod_ff[1][c])
             + (lsr_pkg::PRW+2)'(prod_ff[2][c]);
         v_in[c] = lsr_pkg::VW'(acc >>> 14) + lsr_pkg::VW'(t_w[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         v_ff  <= v_in;
         r1_ff <= r0_ff;
      end
   end

   always_comb begin
      logic signed [lsr_pkg::CW-1:0] rr;
      logic signed [lsr_pkg::CW-1:0] v0;
      logic signed [lsr_pkg::CW-1:0] v1;
      logic signed [lsr_pkg::CW-1:0] v2;
      logic signed [lsr_pkg::CW-1:0] zm;
      logic signed [lsr_pkg::CW-1:0] zp;
      logic signed [lsr_pkg::CW-1:0] nr;
      logic signed [lsr_pkg::CW-1:0] fr;
      logic signed [lsr_pkg::CW-1:0] cd [lsr_pkg::NLANE];
      logic signed [lsr_pkg::CW-1:0] dz [lsr_pkg::NLANE];
      rr = $signed({5'b0, r1_ff});
      v0 = lsr_pkg::CW'(v_ff[0]);
      v1 = lsr_pkg::CW'(v_ff[1]);
      v2 = lsr_pkg::CW'(v_ff[2]);
      nr = lsr_pkg::CW'($signed(clip[31:0]));
      fr = lsr_pkg::CW'($signed(clip[63:32]));
      zm = v2 - rr;
      zp = v2 + rr;
      cd[0] = v0 - rr;
      cd[1] = v0 + rr;
      cd[2] = v1 + rr;
      cd[3] = v1 - rr;
      dz[0] = cd[0][lsr_pkg::CW-1] ? zm : zp;
      dz[1] = cd[1][lsr_pkg::CW-1] ? zp : zm;
      dz[2] = cd[2][lsr_pkg::CW-1] ? zp : zm;
      dz[3] = cd[3][lsr_pkg::CW-1] ? zm : zp;
      for (int l = 0; l < lsr_pkg::NLANE; l++) begin
         if (dz[l] < nr) begin
            dz[l] = nr;
         end
         if (dz[l] > fr) begin
            dz[l] = fr;
         end
         lane_in[l].coord = cd[l];
         lane_in[l].depth = dz[l][lsr_pkg::DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         lane_ff <= lane_in;
      end
   end

   assign lane = lane_ff;

endmodule

@@ rtl/lsr_proj.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_proj
// Projection numerator and operand magnitudes for one edge division.
// ----------------------------------------------------------------------------
module lsr_proj (
   input  logic                  clock,
   input  logic [1:0]            en,
   input  lsr_pkg::lane_type     lane,
   input  logic [15:0]           scale,
   output lsr_pkg::dstage_type   dout
);

   logic signed [lsr_pkg::MW-1:0] prod_ff;
   logic signed [lsr_pkg::DW-1:0] depth_ff;
   lsr_pkg::dstage_type           dout_ff;
   lsr_pkg::dstage_type           dout_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff  <= lane.coord * $signed(scale);
         depth_ff <= lane.depth;
      end
   end

   always_comb begin
      logic signed [lsr_pkg::NW-1:0] num;
      num           = {prod_ff, 4'b0};
      dout_in.rem   = num[lsr_pkg::NW-1] ? lsr_pkg::NW'(-num) : lsr_pkg::NW'(num);
      dout_in.den   = depth_ff[lsr_pkg::DW-1] ? lsr_pkg::DW'(-depth_ff)
                                              : lsr_pkg::DW'(depth_ff);
      dout_in.quo   = '0;
      dout_in.neg   = num[lsr_pkg::NW-1] ^ depth_ff[lsr_pkg::DW-1];
      dout_in.zero  = (depth_ff == '0);
      dout_in.ovf   = (dout_in.rem >= lsr_pkg::NW'({dout_in.den, {lsr_pkg::QB{1'b0}}}));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

@@ rtl/lsr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lsr_div (
   input  logic                  clock,
   input  logic [lsr_pkg::QB-1:0] en,
   input  lsr_pkg::dstage_type   din,
   output lsr_pkg::dstage_type   dout
);

   lsr_pkg::dstage_type st_ff [lsr_pkg::QB];
   lsr_pkg::dstage_type st_w  [lsr_pkg::QB+1];

   assign st_w[0] = din;

   for (genvar k = 0; k < lsr_pkg::QB; k++) begin : g_step
      lsr_pkg::dstage_type nxt;
      logic [lsr_pkg::NW-1:0] sh;

      assign sh = lsr_pkg::NW'(st_w[k].den) << (lsr_pkg::QB - 1 - k);

      always_comb begin
         nxt = st_w[k];
         if (st_w[k].rem >= sh) begin
            nxt.rem = st_w[k].rem - sh;
            nxt.quo[lsr_pkg::QB-1-k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            st_ff[k] <= nxt;
         end
      end

      assign st_w[k+1] = st_ff[k];
   end

   assign dout = st_w[lsr_pkg::QB];

endmodule

@@ rtl/lsr_pix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_pix
// Clamp of the clip coordinate and mapping onto the viewport in pixels.
// ----------------------------------------------------------------------------
module lsr_pix (
   input  logic                  clock,
   input  logic [1:0]            en,
   input  lsr_pkg::dstage_type   din,
   input  logic [15:0]           size,
   input  logic                  flip,
   output logic [15:0]           pix
);

   logic [lsr_pkg::QB:0] t_ff;
   logic [lsr_pkg::QB:0] t_in;
   logic [15:0]          pix_ff;
   logic [33:0]          prod;

   always_comb begin
      logic [lsr_pkg::QB-1:0]      mag;
      logic signed [lsr_pkg::QB:0] ndc;
      if (din.ovf || din.quo > lsr_pkg::NDC_ONE) begin
         mag = lsr_pkg::NDC_ONE;
      end else begin
         mag = din.quo;
      end
      if (din.zero) begin
         ndc = '0;
      end else if (din.neg) begin
         ndc = -$signed({1'b0, mag});
      end else begin
         ndc = $signed({1'b0, mag});
      end
      if (flip) begin
         t_in = (lsr_pkg::QB+1)'($signed({1'b0, lsr_pkg::NDC_ONE}) - ndc);
      end else begin
         t_in = (lsr_pkg::QB+1)'(ndc + $signed({1'b0, lsr_pkg::NDC_ONE}));
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_ff <= t_in;
      end
   end

   assign prod = 34'(t_ff) * 34'(size);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pix_ff <= prod[32:17];
      end
   end

   assign pix = pix_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the light sphere scissor rectangle pipeline.
// ----------------------------------------------------------------------------
// Requests are driven at the falling edge and responses are sampled at the
// rising edge. A predictor computes the rectangle of each accepted request
// from its own copy of the CSRs and queues it; a checker compares every
// response with the oldest queued rectangle. Test tasks cover directed
// corner cases, CSR extremes and random lights under several idle patterns.
// ----------------------------------------------------------------------------
module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [30:0] req_radius = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_rect_left, rsp_rect_right, rsp_rect_top, rsp_rect_bottom;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [5:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic [15:0] top;
      logic [15:0] bottom;
   } rect_type;

   rect_type rect_queue[$];
   logic [63:0] shadow_csr[8];
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int stall_pct = 0;
   localparam int CYCLE_LIMIT = 400000;

   light_sphere_scissor_rect uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic logic signed [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic signed [63:0] sx32(logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [63:0] clamp64(logic signed [63:0] v,
         logic signed [63:0] lo, logic signed [63:0] hi);
      logic signed [63:0] r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   function automatic logic signed [63:0] ndc_of(logic signed [63:0] coord,
         logic signed [63:0] scale, logic signed [63:0] depth);
      logic signed [63:0] q;
      if (depth == 0) q = 0;
      else q = (coord * scale * 16) / depth;
      return clamp64(q, -65536, 65536);
   endfunction

   function automatic logic [15:0] pixel_of(logic signed [63:0] ndc, logic [15:0] size,
         bit flip);
      logic [63:0] t;
      logic [63:0] p;
      t = flip ? (65536 - ndc) : (ndc + 65536);
      p = (t * size) >> 17;
      return p[15:0];
   endfunction

   function automatic rect_type scissor_of(logic [31:0] px, logic [31:0] py,
         logic [31:0] pz, logic [30:0] rad);
      logic signed [63:0] p[3], v[3], acc, r, nr, fr, sxs, sys;
      logic signed [63:0] lx, rx, ty, by, lz, rz, tz, bz;
      logic [15:0] w, h;
      rect_type o;
      p[0] = sx32(px);
      p[1] = sx32(py);
      p[2] = sx32(pz);
      r = {33'd0, rad};
      nr = sx32(shadow_csr[lsr_pkg::REG_CLIP][31:0]);
      fr = sx32(shadow_csr[lsr_pkg::REG_CLIP][63:32]);
      sxs = sx16(shadow_csr[lsr_pkg::REG_PROJ][15:0]);
      sys = sx16(shadow_csr[lsr_pkg::REG_PROJ][31:16]);
      w = shadow_csr[lsr_pkg::REG_VIEWPORT][15:0];
      h = shadow_csr[lsr_pkg::REG_VIEWPORT][31:16];
      for (int c = 0; c < 3; c++) begin
         acc = p[0] * sx16(shadow_csr[lsr_pkg::REG_ROT0][16*c +: 16])
             + p[1] * sx16(shadow_csr[lsr_pkg::REG_ROT1][16*c +: 16])
             + p[2] * sx16(shadow_csr[lsr_pkg::REG_ROT2][16*c +: 16]);
         v[c] = acc >>> 14;
      end
      v[0] += sx32(shadow_csr[lsr_pkg::REG_TRANS_XY][31:0]);
      v[1] += sx32(shadow_csr[lsr_pkg::REG_TRANS_XY][63:32]);
      v[2] += sx32(shadow_csr[lsr_pkg::REG_TRANS_Z][31:0]);
      lx = v[0] - r;
      rx = v[0] + r;
      ty = v[1] + r;
      by = v[1] - r;
      lz = clamp64((lx < 0) ? v[2] - r : v[2] + r, nr, fr);
      rz = clamp64((rx < 0) ? v[2] + r : v[2] - r, nr, fr);
      tz = clamp64((ty < 0) ? v[2] + r : v[2] - r, nr, fr);
      bz = clamp64((by < 0) ? v[2] - r : v[2] + r, nr, fr);
      o.left = pixel_of(ndc_of(lx, sxs, lz), w, 0);
      o.right = pixel_of(ndc_of(rx, sxs, rz), w, 0);
      o.top = pixel_of(ndc_of(ty, sys, tz), h, 1);
      o.bottom = pixel_of(ndc_of(by, sys, bz), h, 1);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rect_queue.size() == 0) begin
            report_mismatch("unexpected response", rsp_rect_left, 16'd0);
         end else begin
            want = rect_queue.pop_front();
            if (rsp_rect_left !== want.left) report_mismatch("left", rsp_rect_left, want.left);
            if (rsp_rect_right !== want.right)
               report_mismatch("right", rsp_rect_right, want.right);
            if (rsp_rect_top !== want.top) report_mismatch("top", rsp_rect_top, want.top);
            if (rsp_rect_bottom !== want.bottom)
               report_mismatch("bottom", rsp_rect_bottom, want.bottom);
         end
      end
   end

   task automatic send_light(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
         logic [30:0] rad);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_radius <= rad;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rect_queue.insert(rect_queue.size(), scissor_of(px, py, pz, rad));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (rect_queue.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(lsr_pkg::csr_reg_type idx, logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 6'(idx) << 3;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      shadow_csr[idx] = value;
      if (idx != lsr_pkg::REG_TRANS_XY && idx != lsr_pkg::REG_CLIP)
         shadow_csr[idx][63:48] = '0;
      if (idx == lsr_pkg::REG_TRANS_Z || idx == lsr_pkg::REG_PROJ
          || idx == lsr_pkg::REG_VIEWPORT)
         shadow_csr[idx][63:32] = '0;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_rot();
      case ($urandom_range(3))
         0: return 16'h4000;
         1: return 16'hc000;
         2: return 16'(($urandom_range(1) ? 1 : -1) * $urandom_range(16384));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic load_view(bit extreme);
      logic [31:0] n, f;
      write_csr(lsr_pkg::REG_ROT0, {16'h0, rand_rot(), rand_rot(), rand_rot()});
      write_csr(lsr_pkg::REG_ROT1, {16'h0, rand_rot(), rand_rot(), rand_rot()});
      write_csr(lsr_pkg::REG_ROT2, {16'h0, rand_rot(), rand_rot(), rand_rot()});
      if (extreme) write_csr(lsr_pkg::REG_TRANS_XY, {$urandom, $urandom});
      else write_csr(lsr_pkg::REG_TRANS_XY,
                     {32'($signed($urandom_range(1 << 22)) - (1 << 21)),
                      32'($signed($urandom_range(1 << 22)) - (1 << 21))});
      write_csr(lsr_pkg::REG_TRANS_Z,
                extreme ? {32'd0, $urandom} : 64'($urandom_range(1 << 22)));
      write_csr(lsr_pkg::REG_PROJ, extreme ? {32'd0, $urandom}
                : {32'd0, 16'($urandom_range(8192)), 16'($urandom_range(8192))});
      n = extreme ? $urandom : $urandom_range(1 << 16);
      f = extreme ? $urandom : n + $urandom_range(1 << 24);
      write_csr(lsr_pkg::REG_CLIP, {f, n});
      write_csr(lsr_pkg::REG_VIEWPORT, extreme ? {32'd0, $urandom}
                : {32'd0, 16'($urandom_range(4096)), 16'($urandom_range(4096))});
   endtask

   task automatic random_lights(int count, bit wide);
      for (int i = 0; i < count; i++) begin
         if (wide || $urandom_range(9) == 0)
            send_light($urandom, $urandom, $urandom, 31'($urandom));
         else
            send_light(32'($signed($urandom_range(1 << 23)) - (1 << 22)),
                       32'($signed($urandom_range(1 << 23)) - (1 << 22)),
                       32'($signed($urandom_range(1 << 23)) - (1 << 22)),
                       31'($urandom_range(1 << 21)));
      end
   endtask

   task automatic test_reset_values;
      send_light(32'h7fffffff, 32'h80000000, 32'h0, 31'h7fffffff);
      send_light(32'h0, 32'h0, 32'h0, 31'h0);
      drain();
   endtask

   task automatic test_directed;
      write_csr(lsr_pkg::REG_ROT0, 48'h0000_0000_4000);
      write_csr(lsr_pkg::REG_ROT1, 48'h0000_4000_0000);
      write_csr(lsr_pkg::REG_ROT2, 48'h4000_0000_0000);
      write_csr(lsr_pkg::REG_TRANS_XY, 64'h0);
      write_csr(lsr_pkg::REG_TRANS_Z, 64'h0005_0000);
      write_csr(lsr_pkg::REG_PROJ, 64'h1000_1000);
      write_csr(lsr_pkg::REG_CLIP, {32'h0100_0000, 32'h0000_1000});
      write_csr(lsr_pkg::REG_VIEWPORT, {16'd1080, 16'd1920});
      send_light(32'h0, 32'h0, 32'h0, 31'h0001_0000);
      send_light(32'h0003_0000, 32'hfffd_0000, 32'h0002_0000, 31'h0);
      send_light(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
      send_light(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
      send_light(32'hffffffff, 32'h1, 32'h80000000, 31'h1);
      drain();
      // A zero-width clip range forces depth zero, which maps to the center.
      write_csr(lsr_pkg::REG_CLIP, 64'h0);
      send_light(32'h0002_0000, 32'h0002_0000, 32'h0, 31'h0001_0000);
      drain();
      // A non-positive near plane lets the depth go negative.
      write_csr(lsr_pkg::REG_CLIP, {32'h0001_0000, 32'hfff0_0000});
      send_light(32'h0002_0000, 32'hfffe_0000, 32'hfff8_0000, 31'h0001_0000);
      send_light(32'h0, 32'h0, 32'h80000000, 31'h0);
      drain();
      // Near above far: far wins.
      write_csr(lsr_pkg::REG_CLIP, {32'h0001_0000, 32'h0010_0000});
      send_light(32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 31'h0000_8000);
      drain();
      write_csr(lsr_pkg::REG_CLIP, {32'h0100_0000, 32'h0000_1000});
      write_csr(lsr_pkg::REG_VIEWPORT, {16'd0, 16'hffff});
      write_csr(lsr_pkg::REG_PROJ, 64'h8000_7fff);
      send_light(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 31'h0002_0000);
      drain();
      write_csr(lsr_pkg::REG_VIEWPORT, {16'hffff, 16'd0});
      write_csr(lsr_pkg::REG_PROJ, 64'h7fff_8000);
      send_light(32'hfffe_0000, 32'h0001_0000, 32'h0004_0000, 31'h0002_0000);
      drain();
   endtask

   task automatic test_phase(int s_idle, int r_stall, int count, bit extreme);
      send_idle = s_idle;
      stall_pct = r_stall;
      load_view(extreme);
      random_lights(count, extreme);
      drain();
   endtask

   initial begin
      for (int i = 0; i < 8; i++) shadow_csr[i] = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_values();
      test_directed();
      for (int k = 0; k < 4; k++) begin
         test_phase(0, 0, 120, k == 3);
         test_phase(77, 0, 70, k == 2);
         test_phase(0, 77, 70, k == 1);
         test_phase(6, 6, 100, k == 0);
      end
      send_idle = 0;
      stall_pct = 0;
      drain();
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
